### src/mcwf_pkg.sv
// Shared types, constants and CRC helper for the Modbus Write Single Coil framer.
// No dependencies; used by modbus_coil_write_framer_top.
package mcwf_pkg;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned CrcStages = 6;

  localparam logic [7:0]  FuncWriteCoil = 8'h05;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  CoilOnHigh = 8'hFF;
  localparam logic [7:0]  ZeroByte = 8'h00;

  localparam logic [7:0]  SlaveAddrReset = 8'h01;
  localparam logic [15:0] CoilAddrReset = 16'h0000;

  // Configuration register indexes.
  localparam logic CfgSlaveAddr = 1'b0;
  localparam logic CfgCoilAddr  = 1'b1;

  // Payload that travels down the CRC pipeline with each word.
  typedef struct packed {
    logic [7:0]  slave_addr;
    logic [15:0] coil_addr;
    logic        coil_on;
    logic [15:0] crc;
  } stage_t;

  // One byte of the Modbus CRC-16 (reflected, polynomial 0xA001).
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Frame byte at a given position, taken from the travelling fields.
  function automatic logic [7:0] frame_byte_at(input logic [2:0] pos,
                                               input stage_t    s);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = s.slave_addr;
      3'd1:    b = FuncWriteCoil;
      3'd2:    b = s.coil_addr[15:8];
      3'd3:    b = s.coil_addr[7:0];
      3'd4:    b = s.coil_on ? CoilOnHigh : ZeroByte;
      3'd5:    b = ZeroByte;
      3'd6:    b = s.crc[7:0];
      3'd7:    b = s.crc[15:8];
      default: b = ZeroByte;
    endcase
    return b;
  endfunction

endpackage

### src/modbus_coil_write_framer_top.sv
// Top level of the Modbus RTU Write Single Coil (function 0x05) frame generator.
// Depends on mcwf_pkg for types, constants and the byte-wise CRC-16 update.

// Each accepted word on the input channel asks for one coil to be switched on
// or off and yields the eight-byte RTU request, one byte per output word: the
// slave address, 0x05, the coil address high then low byte, 0xFF 0x00 for on or
// 0x00 0x00 for off, and the CRC-16 low byte then high byte, the last of which
// carries last_byte_o. The CRC is formed in a six-stage pipeline, one frame byte
// folded in per stage; the last stage hands the frame to the output serialiser.
// The serialiser sends one byte per cycle while out_stall_i is low and so sets
// the sustained request rate; the pipeline keeps taking requests while a frame
// is being sent and only stalls the input once it is full. The slave and coil
// address registers are read as a request enters and should be written only
// while the block is idle.
module modbus_coil_write_framer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        coil_on_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o
);

  localparam int unsigned NStg = mcwf_pkg::CrcStages;

  // Configuration registers.
  logic [7:0]  slave_addr_q;
  logic [15:0] coil_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= mcwf_pkg::SlaveAddrReset;
      coil_addr_q  <= mcwf_pkg::CoilAddrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcwf_pkg::CfgSlaveAddr: slave_addr_q <= cfg_data_i[7:0];
        mcwf_pkg::CfgCoilAddr:  coil_addr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // CRC pipeline: stage s holds the CRC after frame byte s has been folded in.
  logic             vld_q [NStg];
  mcwf_pkg::stage_t stg_q [NStg];
  mcwf_pkg::stage_t stg_d [NStg];
  logic             rdy   [NStg+1];

  // Output serialiser: the whole frame as a shift register plus a byte count.
  logic        ser_vld_q;
  logic [2:0]  cnt_q;
  logic [63:0] frame_q;
  logic        out_take;
  logic        ser_load_ok;

  assign out_take    = ser_vld_q && !out_stall_i;
  assign ser_load_ok = !ser_vld_q || (out_take && (cnt_q == 3'd7));

  // A stage may take new data when it is empty or its contents move on.
  always_comb begin
    rdy[NStg] = ser_load_ok;
    for (int s = NStg - 1; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end

  assign in_stall_o = !rdy[0];

  // Next payload of every stage: the upstream fields with one more CRC byte.
  always_comb begin
    mcwf_pkg::stage_t entry;
    entry.slave_addr = slave_addr_q;
    entry.coil_addr  = coil_addr_q;
    entry.coil_on    = coil_on_i;
    entry.crc        = mcwf_pkg::CrcInit;
    stg_d[0]     = entry;
    stg_d[0].crc = mcwf_pkg::crc_update(mcwf_pkg::CrcInit, slave_addr_q);
    for (int s = 1; s < NStg; s++) begin
      stg_d[s]     = stg_q[s-1];
      stg_d[s].crc = mcwf_pkg::crc_update(stg_q[s-1].crc,
                                          mcwf_pkg::frame_byte_at(3'(s), stg_q[s-1]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NStg; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NStg; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      stg_q[0] <= stg_d[0];
    end
    for (int s = 1; s < NStg; s++) begin
      if (rdy[s] && vld_q[s-1]) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  // Serialiser control: load a complete frame, then shift one byte per word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      cnt_q     <= 3'd0;
    end else if (ser_load_ok && vld_q[NStg-1]) begin
      ser_vld_q <= 1'b1;
      cnt_q     <= 3'd0;
    end else if (out_take) begin
      if (cnt_q == 3'd7) begin
        ser_vld_q <= 1'b0;
      end
      cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load_ok && vld_q[NStg-1]) begin
      frame_q <= {mcwf_pkg::frame_byte_at(3'd0, stg_q[NStg-1]),
                  mcwf_pkg::frame_byte_at(3'd1, stg_q[NStg-1]),
                  mcwf_pkg::frame_byte_at(3'd2, stg_q[NStg-1]),
                  mcwf_pkg::frame_byte_at(3'd3, stg_q[NStg-1]),
                  mcwf_pkg::frame_byte_at(3'd4, stg_q[NStg-1]),
                  mcwf_pkg::frame_byte_at(3'd5, stg_q[NStg-1]),
                  mcwf_pkg::frame_byte_at(3'd6, stg_q[NStg-1]),
                  mcwf_pkg::frame_byte_at(3'd7, stg_q[NStg-1])};
    end else if (out_take) begin
      frame_q <= {frame_q[55:0], 8'h00};
    end
  end

  assign out_valid_o  = ser_vld_q;
  assign frame_byte_o = frame_q[63:56];
  assign last_byte_o  = (cnt_q == 3'd7);

endmodule
